@@ sv/bsad_pkg.sv @@
// Shared types, character codes and defaults for the bulk string array deframer.
`timescale 1ns / 1ps
`default_nettype none

package bsad_pkg;

  localparam int DEF_MAX_ELEMENTS      = 1024;
  localparam int DEF_MAX_STRING_LENGTH = 1048575;

  localparam int KIND_W = 3;
  localparam int DATA_W = 8;
  localparam int IDX_W  = 10;

  localparam logic [DATA_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [DATA_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [DATA_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [DATA_W-1:0] CH_CR     = 8'h0D;
  localparam logic [DATA_W-1:0] CH_LF     = 8'h0A;
  localparam logic [DATA_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [DATA_W-1:0] CH_NINE   = 8'h39;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA  = 3'd0,
    KIND_END   = 3'd1,
    KIND_EMPTY = 3'd2,
    KIND_BAD   = 3'd3,
    KIND_CUT   = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_CNT_BEGIN  = 4'd1,
    PH_CNT_SIGN   = 4'd2,
    PH_CNT_DIGITS = 4'd3,
    PH_CNT_LF     = 4'd4,
    PH_EL_START   = 4'd5,
    PH_LEN_BEGIN  = 4'd6,
    PH_LEN_SIGN   = 4'd7,
    PH_LEN_DIGITS = 4'd8,
    PH_LEN_LF     = 4'd9,
    PH_DATA       = 4'd10,
    PH_TRAIL1     = 4'd11,
    PH_TRAIL2     = 4'd12
  } phase_t;

  typedef struct packed {
    kind_t             kind;
    logic [DATA_W-1:0] data;
    logic [IDX_W-1:0]  element_index;
    logic              last_element;
  } result_t;

endpackage

`default_nettype wire

@@ sv/bulk_string_array_deframer.sv @@
// Top level of the bulk string array deframer.
// Takes a request one byte per transaction and deframes an array of
// length-prefixed bulk strings ('*' count CRLF, then per element '$' length
// CRLF, data bytes and two unchecked trailer bytes). Each data byte comes out
// with its element index, each element closes with an element-end result that
// flags the last one; empty arrays, malformed numbers and arrays cut short get
// results of their own. One byte is taken per clock cycle while the output
// does not stall: a byte passes an input register, one step of the parser
// state machine and a result register before its result, if any, is presented.
// Input stalls only while a result waits on a stalled output.
`timescale 1ns / 1ps
`default_nettype none

module bulk_string_array_deframer #(
  parameter int MAX_ELEMENTS      = bsad_pkg::DEF_MAX_ELEMENTS,
  parameter int MAX_STRING_LENGTH = bsad_pkg::DEF_MAX_STRING_LENGTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [bsad_pkg::DATA_W-1:0] in_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [bsad_pkg::KIND_W-1:0]      out_kind,
  output logic [bsad_pkg::DATA_W-1:0]      out_data,
  output logic [bsad_pkg::IDX_W-1:0]       out_element_index,
  output logic                             out_last_element
);

  logic                        byte_valid;
  logic [bsad_pkg::DATA_W-1:0] byte_q;
  logic                        out_free;
  logic                        step;
  logic                        emit;
  bsad_pkg::result_t           result;

  // advance the parser whenever a byte is held and the result slot can take it
  assign step = byte_valid & out_free;

  bsad_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .take       (step),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  bsad_parse #(
    .MAX_ELEMENTS      (MAX_ELEMENTS),
    .MAX_STRING_LENGTH (MAX_STRING_LENGTH)
  ) u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .byte_q (byte_q),
    .emit   (emit),
    .result (result)
  );

  bsad_out_reg u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (step & emit),
    .result            (result),
    .free              (out_free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_data          (out_data),
    .out_element_index (out_element_index),
    .out_last_element  (out_last_element)
  );

endmodule

`default_nettype wire

@@ sv/bsad_in_reg.sv @@
// Input register: holds one received byte until the parser steps on it.
`timescale 1ns / 1ps
`default_nettype none

module bsad_in_reg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [bsad_pkg::DATA_W-1:0] in_byte,
  input  wire logic                       take,
  output logic                            byte_valid,
  output logic [bsad_pkg::DATA_W-1:0]     byte_q
);

  logic                        valid_r, valid_nxt;
  logic [bsad_pkg::DATA_W-1:0] byte_r, byte_nxt;

  // hold while a registered byte waits for the parser
  assign in_stall = valid_r & ~take;

  always_comb begin
    valid_nxt = in_stall ? valid_r : in_valid;
    byte_nxt  = (in_valid && !in_stall) ? in_byte : byte_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    byte_r <= byte_nxt;
  end

  assign byte_valid = valid_r;
  assign byte_q     = byte_r;

endmodule

`default_nettype wire

@@ sv/bsad_parse.sv @@
// Deframing state machine: phase, counters and decimal accumulator.
`timescale 1ns / 1ps
`default_nettype none

module bsad_parse #(
  parameter int MAX_ELEMENTS      = bsad_pkg::DEF_MAX_ELEMENTS,
  parameter int MAX_STRING_LENGTH = bsad_pkg::DEF_MAX_STRING_LENGTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [bsad_pkg::DATA_W-1:0] byte_q,
  output logic                             emit,
  output bsad_pkg::result_t                result
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int LEN_W = $clog2(MAX_STRING_LENGTH + 1);
  localparam int ACC_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int SUM_W = ACC_W + 4;
  localparam int CE_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int EXT_W = CE_W + bsad_pkg::IDX_W;

  localparam logic [SUM_W-1:0] CNT_BOUND = SUM_W'(MAX_ELEMENTS);
  localparam logic [SUM_W-1:0] LEN_BOUND = SUM_W'(MAX_STRING_LENGTH);

  bsad_pkg::phase_t phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CE_W-1:0]  cur_r, cur_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic             neg_r, neg_nxt;

  logic             is_digit;
  logic [SUM_W-1:0] acc_ext;
  logic [SUM_W-1:0] sum;
  logic [CNT_W:0]   cur_plus;
  logic             is_last;
  logic [EXT_W-1:0] cur_ext;
  logic [bsad_pkg::IDX_W-1:0] cur_idx;

  assign is_digit = (byte_q >= bsad_pkg::CH_ZERO) && (byte_q <= bsad_pkg::CH_NINE);
  assign acc_ext  = {4'b0000, acc_r};
  // acc * 10 + digit; the low nibble of an ASCII digit is its value
  assign sum      = (acc_ext << 3) + (acc_ext << 1) + {{ACC_W{1'b0}}, byte_q[3:0]};
  assign cur_plus = (CNT_W + 1)'(cur_r) + 1'b1;
  assign is_last  = cur_plus >= {1'b0, count_r};
  assign cur_ext  = EXT_W'(cur_r);
  assign cur_idx  = cur_ext[bsad_pkg::IDX_W-1:0];

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    cur_nxt   = cur_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    neg_nxt   = neg_r;
    emit      = 1'b0;
    result    = '0;

    unique case (phase_r)
      bsad_pkg::PH_IDLE: begin
        if (byte_q == bsad_pkg::CH_STAR) begin
          phase_nxt = bsad_pkg::PH_CNT_BEGIN;
          acc_nxt   = '0;
          neg_nxt   = 1'b0;
        end
      end

      bsad_pkg::PH_CNT_BEGIN, bsad_pkg::PH_CNT_SIGN, bsad_pkg::PH_CNT_DIGITS: begin
        priority if (phase_r == bsad_pkg::PH_CNT_BEGIN && byte_q == bsad_pkg::CH_MINUS) begin
          neg_nxt   = 1'b1;
          phase_nxt = bsad_pkg::PH_CNT_SIGN;
        end else if (is_digit && sum <= CNT_BOUND) begin
          acc_nxt   = sum[ACC_W-1:0];
          phase_nxt = bsad_pkg::PH_CNT_DIGITS;
        end else if (!is_digit && phase_r == bsad_pkg::PH_CNT_DIGITS &&
                     byte_q == bsad_pkg::CH_CR) begin
          phase_nxt = bsad_pkg::PH_CNT_LF;
        end else begin
          // malformed or over the bound
          phase_nxt   = bsad_pkg::PH_IDLE;
          acc_nxt     = '0;
          neg_nxt     = 1'b0;
          emit        = 1'b1;
          result.kind = bsad_pkg::KIND_BAD;
        end
      end

      bsad_pkg::PH_CNT_LF: begin
        if (byte_q != bsad_pkg::CH_LF) begin
          phase_nxt   = bsad_pkg::PH_IDLE;
          acc_nxt     = '0;
          neg_nxt     = 1'b0;
          emit        = 1'b1;
          result.kind = bsad_pkg::KIND_BAD;
        end else if (neg_r || acc_r == '0) begin
          phase_nxt   = bsad_pkg::PH_IDLE;
          acc_nxt     = '0;
          neg_nxt     = 1'b0;
          emit        = 1'b1;
          result.kind = bsad_pkg::KIND_EMPTY;
        end else begin
          count_nxt = acc_r[CNT_W-1:0];
          cur_nxt   = '0;
          acc_nxt   = '0;
          phase_nxt = bsad_pkg::PH_EL_START;
        end
      end

      bsad_pkg::PH_EL_START: begin
        if (byte_q != bsad_pkg::CH_DOLLAR) begin
          // consume the byte and drop the rest of the array
          phase_nxt            = bsad_pkg::PH_IDLE;
          emit                 = 1'b1;
          result.kind          = bsad_pkg::KIND_CUT;
          result.element_index = cur_idx;
        end else begin
          acc_nxt   = '0;
          neg_nxt   = 1'b0;
          phase_nxt = bsad_pkg::PH_LEN_BEGIN;
        end
      end

      bsad_pkg::PH_LEN_BEGIN, bsad_pkg::PH_LEN_SIGN, bsad_pkg::PH_LEN_DIGITS: begin
        priority if (phase_r == bsad_pkg::PH_LEN_BEGIN && byte_q == bsad_pkg::CH_MINUS) begin
          neg_nxt   = 1'b1;
          phase_nxt = bsad_pkg::PH_LEN_SIGN;
        end else if (is_digit && sum <= LEN_BOUND) begin
          acc_nxt   = sum[ACC_W-1:0];
          phase_nxt = bsad_pkg::PH_LEN_DIGITS;
        end else if (!is_digit && phase_r == bsad_pkg::PH_LEN_DIGITS &&
                     byte_q == bsad_pkg::CH_CR) begin
          phase_nxt = bsad_pkg::PH_LEN_LF;
        end else begin
          phase_nxt   = bsad_pkg::PH_IDLE;
          acc_nxt     = '0;
          neg_nxt     = 1'b0;
          emit        = 1'b1;
          result.kind = bsad_pkg::KIND_BAD;
        end
      end

      bsad_pkg::PH_LEN_LF: begin
        acc_nxt = '0;
        neg_nxt = 1'b0;
        if (byte_q != bsad_pkg::CH_LF) begin
          phase_nxt   = bsad_pkg::PH_IDLE;
          emit        = 1'b1;
          result.kind = bsad_pkg::KIND_BAD;
        end else if (neg_r && acc_r != '0) begin
          // null string: close the element straight away
          emit                 = 1'b1;
          result.kind          = bsad_pkg::KIND_END;
          result.element_index = cur_idx;
          result.last_element  = is_last;
          if (is_last) begin
            phase_nxt = bsad_pkg::PH_IDLE;
          end else begin
            cur_nxt   = cur_r + 1'b1;
            phase_nxt = bsad_pkg::PH_EL_START;
          end
        end else begin
          rem_nxt   = acc_r[LEN_W-1:0];
          phase_nxt = (acc_r == '0) ? bsad_pkg::PH_TRAIL1 : bsad_pkg::PH_DATA;
        end
      end

      bsad_pkg::PH_DATA: begin
        if (rem_r != '0) begin
          rem_nxt = rem_r - 1'b1;
        end
        if (rem_r <= LEN_W'(1)) begin
          phase_nxt = bsad_pkg::PH_TRAIL1;
        end
        emit                 = 1'b1;
        result.kind          = bsad_pkg::KIND_DATA;
        result.data          = byte_q;
        result.element_index = cur_idx;
      end

      bsad_pkg::PH_TRAIL1: begin
        phase_nxt = bsad_pkg::PH_TRAIL2;
      end

      bsad_pkg::PH_TRAIL2: begin
        emit                 = 1'b1;
        result.kind          = bsad_pkg::KIND_END;
        result.element_index = cur_idx;
        result.last_element  = is_last;
        if (is_last) begin
          phase_nxt = bsad_pkg::PH_IDLE;
        end else begin
          cur_nxt   = cur_r + 1'b1;
          phase_nxt = bsad_pkg::PH_EL_START;
        end
      end

      default: begin
        phase_nxt = bsad_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bsad_pkg::PH_IDLE;
      count_r <= '0;
      cur_r   <= '0;
      acc_r   <= '0;
      rem_r   <= '0;
      neg_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      cur_r   <= cur_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
      neg_r   <= neg_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/bsad_out_reg.sv @@
// Result register: holds one result transaction until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

module bsad_out_reg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        load,
  input  wire bsad_pkg::result_t           result,
  output logic                             free,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [bsad_pkg::KIND_W-1:0]      out_kind,
  output logic [bsad_pkg::DATA_W-1:0]      out_data,
  output logic [bsad_pkg::IDX_W-1:0]       out_element_index,
  output logic                             out_last_element
);

  logic              valid_r, valid_nxt;
  bsad_pkg::result_t res_r, res_nxt;

  assign free = ~valid_r | ~out_stall;

  always_comb begin
    priority if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
    res_nxt = load ? result : res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_valid         = valid_r;
  assign out_kind          = res_r.kind;
  assign out_data          = res_r.data;
  assign out_element_index = res_r.element_index;
  assign out_last_element  = res_r.last_element;

endmodule

`default_nettype wire
